// File: rtl/lps_pkg.sv
// Shared constants and types for the LIKE pattern selectivity block.
// Used by lps_front, lps_queue, lps_back and like_pattern_selectivity.
`timescale 1ns / 1ps

package lps_pkg;

    // Defaults for the top-level parameters.
    localparam int HEADER_BYTES_DEF = 4;
    localparam int FRAC_BITS_DEF    = 31;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Fixed field widths.
    localparam int HDR_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int SCALE_W = 32;

    // Scale values in UQ16.16.
    localparam logic [SCALE_W-1:0] SCALE_LIMIT_RST = 32'd9830400;
    localparam logic [SCALE_W-1:0] SCALE_ONE       = 32'd65536;

    // Pattern characters.
    localparam logic [BYTE_W-1:0] CHAR_PCT = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_USC = 8'h5F;
    localparam logic [BYTE_W-1:0] CHAR_BSL = 8'h5C;

    // Control bits that travel with each finished datum.
    typedef struct packed {
        logic anchor;
        logic is_null;
    } job_ctl_t;

    localparam int JOB_CTL_W = $bits(job_ctl_t);

endpackage

// File: rtl/lps_front.sv
// Front end: takes one datum byte per cycle unless lps_queue is full and keeps the running selectivity.
// Depends on lps_pkg; pushes one job per datum into lps_queue.
`timescale 1ns / 1ps

module lps_front #(
    parameter int HEADER_BYTES = lps_pkg::HEADER_BYTES_DEF,
    parameter int FRAC_BITS    = lps_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lps_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last_byte,
    input  logic                        is_null,
    input  logic                        full,
    output logic                        push,
    output lps_pkg::job_ctl_t           push_ctl,
    output logic [FRAC_BITS:0]          push_sel
);
    import lps_pkg::*;

    localparam int SEL_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * SEL_W;

    localparam logic [63:0] ONE64     = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FIXED64   = (ONE64 + 64'd2) / 64'd5;
    localparam logic [63:0] ANY64     = (ONE64 * 64'd99 + 64'd50) / 64'd100;
    localparam logic [63:0] ROLLOFF64 = (ONE64 * 64'd7 + 64'd25) / 64'd50;

    localparam logic [SEL_W-1:0]  FX_ONE     = ONE64[SEL_W-1:0];
    localparam logic [SEL_W-1:0]  C_FIXED    = FIXED64[SEL_W-1:0];
    localparam logic [SEL_W-1:0]  C_ANY      = ANY64[SEL_W-1:0];
    localparam logic [SEL_W-1:0]  C_ROLLOFF  = ROLLOFF64[SEL_W-1:0];
    localparam logic [PROD_W-1:0] FX_HALF    = PROD_W'(64'd1 << (FRAC_BITS - 1));

    logic [HDR_W-1:0]  hdr_reg,  hdr_next;
    logic              skip_reg, skip_next;
    logic              esc_reg,  esc_next;
    logic [SEL_W-1:0]  sel_reg,  sel_next;
    logic [SEL_W-1:0]  fcf_reg,  fcf_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;

    logic              accept;
    logic              in_header;
    logic              use_any;
    logic [SEL_W-1:0]  mul_b;
    logic [PROD_W-1:0] sel_prod;
    logic [SEL_W-1:0]  sel_mul;
    logic [SEL_W-1:0]  one_minus_f;
    logic [PROD_W-1:0] roll_prod;
    logic [SEL_W-1:0]  roll_term;
    logic [SEL_W:0]    fcf_sum;
    logic [SEL_W-1:0]  fcf_upd;
    logic [SEL_W-1:0]  sel_proc;

    assign accept    = in_valid && !full;
    assign in_stall  = full;
    assign in_header = (hdr_reg < HDR_W'(HEADER_BYTES));

    // One multiplier serves both the literal and the single-char wildcard.
    assign use_any  = !esc_reg && (data_byte == CHAR_USC);
    assign mul_b    = use_any ? C_ANY : fcf_reg;
    assign sel_prod = PROD_W'(sel_reg) * PROD_W'(mul_b);
    assign sel_mul  = SEL_W'((sel_prod + FX_HALF) >> FRAC_BITS);

    // Fixed-char factor moves a fraction of the way toward one per literal.
    assign one_minus_f = FX_ONE - fcf_reg;
    assign roll_prod   = PROD_W'(one_minus_f) * PROD_W'(C_ROLLOFF);
    assign roll_term   = SEL_W'((roll_prod + FX_HALF) >> FRAC_BITS);
    assign fcf_sum     = (fcf_reg < FX_ONE) ? ({1'b0, fcf_reg} + {1'b0, roll_term})
                                            : {1'b0, fcf_reg};
    assign fcf_upd     = (fcf_sum > {1'b0, FX_ONE}) ? FX_ONE : fcf_sum[SEL_W-1:0];

    always_comb
    begin
        hdr_next  = hdr_reg;
        skip_next = skip_reg;
        esc_next  = esc_reg;
        sel_next  = sel_reg;
        fcf_next  = fcf_reg;
        prev_next = prev_reg;
        sel_proc  = sel_reg;
        push      = 1'b0;
        push_ctl  = '0;

        if (accept)
        begin
            if (is_null)
            begin
                push             = 1'b1;
                push_ctl.is_null = 1'b1;
            end
            else
            begin
                if (in_header)
                begin
                    hdr_next = hdr_reg + 1'b1;
                end
                else if (!(skip_reg && ((data_byte == CHAR_PCT) ||
                                        (data_byte == CHAR_USC))))
                begin
                    skip_next = 1'b0;
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        sel_proc = sel_mul;
                        fcf_next = fcf_upd;
                    end
                    else if (data_byte == CHAR_USC)
                    begin
                        sel_proc = sel_mul;
                    end
                    else if (data_byte == CHAR_PCT)
                    begin
                        sel_proc = sel_reg;
                    end
                    else if (data_byte == CHAR_BSL)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        sel_proc = sel_mul;
                        fcf_next = fcf_upd;
                    end
                end
                sel_next  = sel_proc;
                prev_next = data_byte;
                if (last_byte)
                begin
                    push            = 1'b1;
                    push_ctl.anchor = in_header || (data_byte != CHAR_PCT) ||
                                      (prev_reg == CHAR_BSL);
                end
            end

            // A finished datum leaves the per-datum state at its start values.
            if (is_null || last_byte)
            begin
                hdr_next  = '0;
                skip_next = 1'b1;
                esc_next  = 1'b0;
                sel_next  = FX_ONE;
                fcf_next  = C_FIXED;
                prev_next = '0;
            end
        end
    end

    assign push_sel = sel_proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg  <= '0;
            skip_reg <= 1'b1;
            esc_reg  <= 1'b0;
            sel_reg  <= FX_ONE;
            fcf_reg  <= C_FIXED;
            prev_reg <= '0;
        end
        else
        begin
            hdr_reg  <= hdr_next;
            skip_reg <= skip_next;
            esc_reg  <= esc_next;
            sel_reg  <= sel_next;
            fcf_reg  <= fcf_next;
            prev_reg <= prev_next;
        end
    end

endmodule

// File: rtl/lps_queue.sv
// Short FIFO that decouples the byte front end from the divider back end.
// Depends on lps_pkg only for the default depth; data width is a parameter.
`timescale 1ns / 1ps

module lps_queue #(
    parameter int DATA_W = 34,
    parameter int DEPTH  = lps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output logic              full,
    output logic              empty
);
    import lps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign head_data = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow a write");

endmodule

// File: rtl/lps_back.sv
// Back end: applies the end anchor factor, divides for the reciprocal and clamps.
// Depends on lps_pkg; pops jobs from lps_queue and drives the result register.
`timescale 1ns / 1ps

module lps_back #(
    parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    output logic                        pop,
    input  lps_pkg::job_ctl_t           head_ctl,
    input  logic [FRAC_BITS:0]          head_sel,
    input  logic [lps_pkg::SCALE_W-1:0] scale_limit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lps_pkg::SCALE_W-1:0] scale_factor
);
    import lps_pkg::*;

    localparam int SEL_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * SEL_W;
    localparam int NUM_W  = FRAC_BITS + 17;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    localparam logic [63:0] ONE64    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] ANCHOR64 = (ONE64 * 64'd19 + 64'd10) / 64'd20;
    localparam logic [SEL_W-1:0]  C_ANCHOR = ANCHOR64[SEL_W-1:0];
    localparam logic [PROD_W-1:0] FX_HALF  = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [NUM_W-1:0]  NUM_BASE = NUM_W'(1) << (NUM_W - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_CLAMP = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]         st_reg,   st_next;
    job_ctl_t           ctl_reg,  ctl_next;
    logic [SEL_W-1:0]   div_reg,  div_next;
    logic [NUM_W-1:0]   num_reg,  num_next;
    logic [SEL_W-1:0]   rem_reg,  rem_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [SCALE_W-1:0] res_reg,  res_next;
    logic               ov_reg,   ov_next;
    logic [SCALE_W-1:0] od_reg,   od_next;

    logic [PROD_W-1:0]  anc_prod;
    logic [SEL_W:0]     rem_sh;
    logic               rem_ge;
    logic               out_free;

    assign anc_prod = PROD_W'(div_reg) * PROD_W'(C_ANCHOR);
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, div_reg});
    assign out_free = !ov_reg || !out_stall;

    always_comb
    begin
        st_next  = st_reg;
        ctl_next = ctl_reg;
        div_next = div_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        ov_next  = ov_reg && out_stall;
        od_next  = od_reg;
        pop      = 1'b0;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    ctl_next = head_ctl;
                    div_next = head_sel;
                    st_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (ctl_reg.anchor)
                begin
                    div_next = SEL_W'((anc_prod + FX_HALF) >> FRAC_BITS);
                end
                st_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (ctl_reg.is_null)
                begin
                    res_next = SCALE_ONE;
                    st_next  = ST_OUT;
                end
                else if (div_reg == '0)
                begin
                    res_next = scale_limit;
                    st_next  = ST_OUT;
                end
                else
                begin
                    // Half the divisor is added so that the quotient rounds.
                    num_next = NUM_BASE + NUM_W'(div_reg >> 1);
                    rem_next = '0;
                    cnt_next = CNT_W'(NUM_W);
                    st_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring division, one quotient bit per cycle into num_reg.
                rem_next = rem_ge ? SEL_W'(rem_sh - {1'b0, div_reg}) : rem_sh[SEL_W-1:0];
                num_next = {num_reg[NUM_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    st_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                res_next = (num_reg > NUM_W'(scale_limit)) ? scale_limit
                                                          : num_reg[SCALE_W-1:0];
                st_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    od_next = res_reg;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = ov_reg;
    assign scale_factor = od_reg;

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        od_reg  <= od_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            ctl_reg <= '0;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            ctl_reg <= ctl_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

endmodule

// File: rtl/like_pattern_selectivity.sv
// Top level of the LIKE pattern selectivity block.
// Depends on lps_pkg and instantiates lps_front, lps_queue and lps_back.
//
// Usage: the bytes of one LIKE pattern datum arrive on the input channel
// (data_byte, last_byte, is_null; in_valid and in_stall), header bytes first.
// A transfer happens at a rising edge with in_valid high and in_stall low.
// One result transfer (scale_factor, UQ16.16) leaves on the output channel
// (out_valid and out_stall) for every byte marked last_byte and for every
// null item; other bytes give no result.
// Bytes are taken at one per cycle while in_stall is low. A finished datum
// enters a QUEUE_DEPTH-entry queue (two by default); the back end then works
// on one datum at a time: anchor multiply, a restoring divider that yields one
// quotient bit per cycle, a clamp to scale_limit and the output register. A
// null item skips the divider and the clamp. The divider sets the rate per
// datum. in_stall rises only while the queue holds QUEUE_DEPTH finished data.
// The scale_limit register is written over the cfg channel (cfg_valid,
// cfg_ready, cfg_data); cfg_ready is always high. Reset sets scale_limit to
// 150.0, empties the queue and the output register and clears the datum
// state. A stalled result holds on the output port until it is taken.
`timescale 1ns / 1ps

module like_pattern_selectivity #(
    parameter int HEADER_BYTES = lps_pkg::HEADER_BYTES_DEF,
    parameter int FRAC_BITS    = lps_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH  = lps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lps_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last_byte,
    input  logic                        is_null,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lps_pkg::SCALE_W-1:0] scale_factor,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lps_pkg::SCALE_W-1:0] cfg_data
);
    import lps_pkg::*;

    localparam int SEL_W = FRAC_BITS + 1;
    localparam int JOB_W = JOB_CTL_W + SEL_W;

    // The only configuration register; writes are taken in any cycle.
    logic [SCALE_W-1:0] limit_reg;

    logic             q_push;
    job_ctl_t         q_push_ctl;
    logic [SEL_W-1:0] q_push_sel;
    logic [JOB_W-1:0] q_push_data;
    logic [JOB_W-1:0] q_head_data;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    job_ctl_t         q_head_ctl;
    logic [SEL_W-1:0] q_head_sel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= SCALE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    lps_front #(
        .HEADER_BYTES (HEADER_BYTES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .is_null   (is_null),
        .full      (q_full),
        .push      (q_push),
        .push_ctl  (q_push_ctl),
        .push_sel  (q_push_sel)
    );

    // Each queue entry carries the control bits above the selectivity.
    assign q_push_data = {q_push_ctl, q_push_sel};
    assign q_head_ctl  = job_ctl_t'(q_head_data[JOB_W-1:SEL_W]);
    assign q_head_sel  = q_head_data[SEL_W-1:0];

    lps_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lps_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .pop          (q_pop),
        .head_ctl     (q_head_ctl),
        .head_sel     (q_head_sel),
        .scale_limit  (limit_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scale_factor (scale_factor)
    );

endmodule
